>>> rtl/tgarle_pkg.sv
// Package for the TGA run-length pixel decoder.
// Holds the count width, status and register index codes, and the result type.
// It depends on nothing else.
package tgarle_pkg;

	localparam int COUNT_WIDTH = 24;

	localparam int HDR_RUN_BIT = 7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;
	localparam logic [1:0] ST_CLIP  = 2'd3;

	localparam logic [0:0] CFG_FOUR_BYTE   = 1'b0;
	localparam logic [0:0] CFG_PIXEL_TOTAL = 1'b1;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		logic       pixel_valid;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] repeat_res;
		logic [1:0] status;
	} pixel_res_t;

endpackage

>>> rtl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
// Decodes one compressed byte per cycle, while input stall is low, into pixels with a repeat count.
// It depends on tgarle_pkg.

// The block takes one byte of TGA run-length data per cycle while input stall is low and may
// take a byte in every such cycle. A packet header byte starts a run (bit 7 set) or a group
// of literal pixels, each (low seven bits + 1) long. A run leaves as a single transaction
// carrying its repeat count, clipped with status 3 if it passes the pixel total; a literal
// pixel leaves with a count of one. A pixel completes on the byte that finishes it, and its
// transaction goes into the output register, or into the one skid register while the
// output is held, so input stall rises only when both hold a result that the downstream
// side has not yet taken. A byte marked as the end of the buffer returns the decoder to its
// start state, and the registers should be written only while no transaction is outstanding.
module tga_rle_pixel_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pixel_valid,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [7:0]  repeat_res,
	output logic [1:0]  status,
	input  logic        cfg_write_en,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic                   four_byte_q;
	logic [23:0]            pixel_total_q;
	logic                   in_packet_q, in_packet_d;
	logic                   run_packet_q, run_packet_d;
	logic [7:0]             packet_left_q, packet_left_d;
	logic [1:0]             byte_index_q, byte_index_d;
	tgarle_pkg::count_t     pixels_left_q, pixels_left_d;
	logic                   image_done_q, image_done_d;
	logic [7:0]             blue_q, green_q, red_q;
	logic                   store_blue, store_green, store_red;

	tgarle_pkg::pixel_res_t res;
	logic                   res_v;
	tgarle_pkg::pixel_res_t out_q, skid_q;
	logic                   out_valid_q, skid_valid_q;

	logic                   in_take, out_take, last_byte, clip, done;
	logic [7:0]             count, count_out;
	tgarle_pkg::count_t     count_ext, load_left;

	assign in_take   = in_valid & ~skid_valid_q;
	assign out_take  = out_valid_q & ~out_stall;
	assign last_byte = four_byte_q ? (byte_index_q == 2'd3) : byte_index_q[1];
	assign count     = run_packet_q ? packet_left_q : 8'd1;
	assign count_ext = tgarle_pkg::count_t'(count);
	assign clip      = count_ext > pixels_left_q;
	assign done      = count_ext >= pixels_left_q;
	assign count_out = clip ? pixels_left_q[7:0] : count;
	assign load_left = tgarle_pkg::count_t'(pixel_total_q);

	always_comb begin
		in_packet_d   = in_packet_q;
		run_packet_d  = run_packet_q;
		packet_left_d = packet_left_q;
		byte_index_d  = byte_index_q;
		pixels_left_d = pixels_left_q;
		image_done_d  = image_done_q;
		store_blue    = 1'b0;
		store_green   = 1'b0;
		store_red     = 1'b0;
		res           = '0;
		res_v         = 1'b0;
		if (in_take && !image_done_q) begin
			if (!in_packet_q) begin
				run_packet_d  = data_byte[tgarle_pkg::HDR_RUN_BIT];
				packet_left_d = {1'b0, data_byte[6:0]} + 8'd1;
				byte_index_d  = 2'd0;
				in_packet_d   = 1'b1;
				if (end_of_buffer) begin
					res_v      = 1'b1;
					res.status = tgarle_pkg::ST_TRUNC;
				end
			end else if (last_byte) begin
				packet_left_d   = run_packet_q ? 8'd0 : packet_left_q - 8'd1;
				in_packet_d     = (packet_left_d != 8'd0);
				pixels_left_d   = pixels_left_q - tgarle_pkg::count_t'(count_out);
				image_done_d    = done;
				byte_index_d    = 2'd0;
				res_v           = 1'b1;
				res.pixel_valid = 1'b1;
				res.blue        = blue_q;
				res.green       = green_q;
				res.red         = (byte_index_q == 2'd2) ? data_byte : red_q;
				res.alpha       = (four_byte_q && byte_index_q == 2'd3) ? data_byte : 8'd0;
				res.repeat_res  = count_out;
				if (end_of_buffer && !done) begin
					res.status = tgarle_pkg::ST_TRUNC;
				end else if (clip) begin
					res.status = tgarle_pkg::ST_CLIP;
				end else if (done) begin
					res.status = tgarle_pkg::ST_DONE;
				end else begin
					res.status = tgarle_pkg::ST_OK;
				end
			end else begin
				unique case (byte_index_q)
					2'd0: store_blue = 1'b1;
					2'd1: store_green = 1'b1;
					2'd2: store_red = 1'b1;
					default: ;
				endcase
				byte_index_d = byte_index_q + 2'd1;
				if (end_of_buffer) begin
					res_v      = 1'b1;
					res.status = tgarle_pkg::ST_TRUNC;
				end
			end
		end
		if (in_take && end_of_buffer) begin
			in_packet_d   = 1'b0;
			run_packet_d  = 1'b0;
			packet_left_d = 8'd0;
			byte_index_d  = 2'd0;
			pixels_left_d = load_left;
			image_done_d  = (load_left == '0);
		end
		if (cfg_write_en && cfg_index == tgarle_pkg::CFG_PIXEL_TOTAL) begin
			pixels_left_d = tgarle_pkg::count_t'(cfg_data);
			image_done_d  = (tgarle_pkg::count_t'(cfg_data) == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_byte_q   <= 1'b0;
			pixel_total_q <= 24'd1;
			in_packet_q   <= 1'b0;
			run_packet_q  <= 1'b0;
			packet_left_q <= 8'd0;
			byte_index_q  <= 2'd0;
			pixels_left_q <= tgarle_pkg::count_t'(1);
			image_done_q  <= 1'b0;
		end else begin
			in_packet_q   <= in_packet_d;
			run_packet_q  <= run_packet_d;
			packet_left_q <= packet_left_d;
			byte_index_q  <= byte_index_d;
			pixels_left_q <= pixels_left_d;
			image_done_q  <= image_done_d;
			if (cfg_write_en) begin
				if (cfg_index == tgarle_pkg::CFG_FOUR_BYTE) begin
					four_byte_q <= cfg_data[0];
				end else begin
					pixel_total_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_blue) begin
			blue_q <= data_byte;
		end
		if (store_green) begin
			green_q <= data_byte;
		end
		if (store_red) begin
			red_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_v;
			end
		end else if (res_v) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_v) begin
			skid_q <= res;
		end
	end

	assign in_stall    = skid_valid_q;
	assign out_valid   = out_valid_q;
	assign pixel_valid = out_q.pixel_valid;
	assign red         = out_q.red;
	assign green       = out_q.green;
	assign blue        = out_q.blue;
	assign alpha       = out_q.alpha;
	assign repeat_res  = out_q.repeat_res;
	assign status      = out_q.status;

endmodule

>>> rtl/tgarle_checker.sv
// Port checker for the TGA run-length pixel decoder, with its bind statement.
// It depends on tgarle_pkg and is attached to tga_rle_pixel_decoder.
module tgarle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        pixel_valid,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [7:0]  alpha,
	input logic [7:0]  repeat_res,
	input logic [1:0]  status
);

	// A stalled transaction holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_valid) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(alpha)
			&& $stable(repeat_res) && $stable(status))
		else $error("stalled result changed");

	// A transaction without a pixel only reports truncation and carries zero fields.
	a_empty_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> status == tgarle_pkg::ST_TRUNC && red == 8'd0
			&& green == 8'd0 && blue == 8'd0 && alpha == 8'd0 && repeat_res == 8'd0)
		else $error("empty result with bad fields");

	// A pixel always covers between one and 128 pixels.
	a_repeat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid |-> repeat_res != 8'd0 && repeat_res <= 8'd128)
		else $error("repeat count out of range");

	// Input stall rises only behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall) && out_valid)
		else $error("input stalled without a held result");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (.*);
